### rtl/adaptive_voltage_table_controller_assert.svh
// Assertion macros for the adaptive voltage table controller.
`ifndef ADAPTIVE_VOLTAGE_TABLE_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_VOLTAGE_TABLE_CONTROLLER_ASSERT_SVH

// Checks an implication on every clock edge outside reset.
`define AVTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property that is expected to hold in reset as well.
`define AVTC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/avtc_pkg.sv
// Shared types and constants for the adaptive voltage table controller.
package avtc_pkg;

    localparam int MAX_LEVELS_DEF = 32;
    localparam int TEMP_BANDS_DEF = 16;

    localparam logic [11:0] RESET_VMAX    = 12'd1300;
    localparam logic [11:0] RESET_VMIN    = 12'd750;
    localparam logic [7:0]  RESET_VSTEP   = 8'd25;
    localparam logic [5:0]  RESET_FCOUNT  = 6'd32;

    typedef enum logic [2:0] {
        CFG_ENABLE = 3'd0,
        CFG_FCOUNT = 3'd1,
        CFG_VMIN   = 3'd2,
        CFG_VMAX   = 3'd3,
        CFG_VSTEP  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  freq_index;
        logic        begin_req;
        logic [3:0]  temperature;
        logic [31:0] delay_status;
    } avtc_req_t;

    typedef struct packed {
        logic        status;
        logic        drive_valid;
        logic [11:0] drive_voltage;
        logic        delay_error;
        logic        at_max_warning;
    } avtc_rsp_t;

    typedef struct packed {
        logic        enable;
        logic [5:0]  freq_count;
        logic [11:0] vmin_mv;
        logic [11:0] vmax_mv;
        logic [7:0]  vstep_mv;
    } avtc_cfg_t;

    typedef enum logic [1:0] {
        KIND_PASS   = 2'd0,
        KIND_CHANGE = 2'd1,
        KIND_TICK   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ERROR = 2'd1,
        ACT_RAISE = 2'd2,
        ACT_LOWER = 2'd3
    } action_t;

    typedef struct packed {
        kind_t      kind;
        logic       out_of_range;
        logic       begin_req;
        logic [4:0] level;
        logic [3:0] band;
        action_t    action;
    } avtc_item_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } avtc_bstat_t;

    typedef enum logic [3:0] {
        ST_CLEAR     = 4'd0,
        ST_IDLE      = 4'd1,
        ST_RAISE     = 4'd2,
        ST_LOW_RD    = 4'd3,
        ST_LOW_CHK   = 4'd4,
        ST_SWEEP_RD  = 4'd5,
        ST_SWEEP_CMP = 4'd6,
        ST_DRV_RD    = 4'd7,
        ST_DRV       = 4'd8
    } state_t;

endpackage

### rtl/adaptive_voltage_table_controller.sv
// Top level of the adaptive voltage table controller.
// Flow: a request passes the front hold register and the queue before the back stage pops it.
// A pass-through result is registered from idle; a change or plain tick reads, then drives; a raising
// tick first rewrites the levels in use and a lowering tick sweeps the levels below, on the single table port.
// One request is in the back stage at a time; the queue holds two more and the front one more.
// After reset the table is cleared one entry per cycle (512 entries at default size).
module adaptive_voltage_table_controller #(
    parameter int MAX_LEVELS = avtc_pkg::MAX_LEVELS_DEF,
    parameter int TEMP_BANDS = avtc_pkg::TEMP_BANDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  avtc_pkg::avtc_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output avtc_pkg::avtc_rsp_t rsp
);
    import avtc_pkg::*;

    `include "adaptive_voltage_table_controller_assert.svh"

    avtc_cfg_t   cfg_reg;
    logic        push;
    logic        push_ready;
    avtc_item_t  push_item;
    logic        q_valid;
    avtc_item_t  q_item;
    avtc_bstat_t bstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.freq_count <= RESET_FCOUNT;
            cfg_reg.vmin_mv    <= RESET_VMIN;
            cfg_reg.vmax_mv    <= RESET_VMAX;
            cfg_reg.vstep_mv   <= RESET_VSTEP;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE: cfg_reg.enable     <= cfg_data[0];
                CFG_FCOUNT: cfg_reg.freq_count <= cfg_data[5:0];
                CFG_VMIN:   cfg_reg.vmin_mv    <= cfg_data;
                CFG_VMAX:   cfg_reg.vmax_mv    <= cfg_data;
                CFG_VSTEP:  cfg_reg.vstep_mv   <= cfg_data[7:0];
                default:    cfg_reg.enable     <= cfg_reg.enable;
            endcase
        end
    end

    avtc_front #(
        .MAX_LEVELS (MAX_LEVELS),
        .TEMP_BANDS (TEMP_BANDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    avtc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (bstat.pop),
        .pop_item   (q_item)
    );

    avtc_back #(
        .MAX_LEVELS (MAX_LEVELS),
        .TEMP_BANDS (TEMP_BANDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item       (q_item),
        .bstat      (bstat),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    `AVTC_ASSERT(a_no_pop_clearing, bstat.clearing |-> !bstat.pop, "pop during table clear")
    `AVTC_ASSERT(a_drive_ok, rsp_valid && rsp.drive_valid |-> !rsp.status, "drive with error")
    `AVTC_ASSERT(a_volt_zero, rsp_valid && !rsp.drive_valid |-> rsp.drive_voltage == 12'd0, "stray")
    `AVTC_ASSERT(a_pop_empty, bstat.pop |-> q_valid, "pop from empty queue")

endmodule

### rtl/avtc_front.sv
// Front stage: accepts requests and classifies them into queue items.
module avtc_front #(
    parameter int MAX_LEVELS = avtc_pkg::MAX_LEVELS_DEF,
    parameter int TEMP_BANDS = avtc_pkg::TEMP_BANDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  avtc_pkg::avtc_cfg_t cfg,
    input  logic                req_valid,
    output logic                req_ready,
    input  avtc_pkg::avtc_req_t req,
    output logic                push,
    input  logic                push_ready,
    output avtc_pkg::avtc_item_t push_item
);
    import avtc_pkg::*;

    localparam int CW = $clog2(MAX_LEVELS + 1);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    avtc_item_t  hold_reg;
    avtc_item_t  hold_next;
    logic [CW-1:0] levels;
    logic [1:0]  cpu_code;
    logic [1:0]  vu_code;
    logic [1:0]  l2_code;
    logic        accept;

    assign req_ready = !hold_valid_reg || push_ready;
    assign accept    = req_valid && req_ready;
    assign push      = hold_valid_reg;
    assign push_item = hold_reg;

    assign levels = ({3'b0, cfg.freq_count} > 9'(MAX_LEVELS)) ? CW'(MAX_LEVELS)
                                                               : CW'(cfg.freq_count);
    assign cpu_code = {req.delay_status[24], req.delay_status[16]};
    assign vu_code  = {req.delay_status[29], req.delay_status[21]};
    assign l2_code  = {req.delay_status[30], req.delay_status[22]};

    always_comb
    begin
        hold_next              = hold_reg;
        hold_valid_next        = hold_valid_reg;
        if (push && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next        = 1'b1;
            hold_next.kind         = KIND_PASS;
            hold_next.out_of_range = 1'b0;
            hold_next.begin_req    = req.begin_req;
            hold_next.level        = req.freq_index;
            hold_next.band         = ({28'b0, req.temperature} >= 32'(TEMP_BANDS))
                                     ? 4'(TEMP_BANDS - 1) : req.temperature;
            hold_next.action       = ACT_NONE;
            if (cpu_code == 2'd3 || vu_code == 2'd3 || l2_code == 2'd3)
            begin
                hold_next.action = ACT_ERROR;
            end
            else if (cpu_code == 2'd2 || vu_code == 2'd2 || l2_code == 2'd2)
            begin
                hold_next.action = ACT_RAISE;
            end
            else if (cpu_code == 2'd1 && vu_code == 2'd1 && l2_code == 2'd1)
            begin
                hold_next.action = ACT_LOWER;
            end
            if (cfg.enable)
            begin
                if (req.cmd)
                begin
                    hold_next.kind = KIND_TICK;
                end
                else if ({4'b0, req.freq_index} >= 9'(levels))
                begin
                    hold_next.out_of_range = 1'b1;
                end
                else
                begin
                    hold_next.kind = KIND_CHANGE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

### rtl/avtc_queue.sv
// Two-entry queue between the front and back stages.
module avtc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 push_ready,
    input  avtc_pkg::avtc_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output avtc_pkg::avtc_item_t pop_item
);
    import avtc_pkg::*;

    avtc_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/avtc_back.sv
// Back stage: table memory, voltage state and the item sequencer.
module avtc_back #(
    parameter int MAX_LEVELS = avtc_pkg::MAX_LEVELS_DEF,
    parameter int TEMP_BANDS = avtc_pkg::TEMP_BANDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  avtc_pkg::avtc_cfg_t   cfg,
    input  logic                  item_valid,
    input  avtc_pkg::avtc_item_t  item,
    output avtc_pkg::avtc_bstat_t bstat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output avtc_pkg::avtc_rsp_t   rsp
);
    import avtc_pkg::*;

    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int BW    = (TEMP_BANDS > 1) ? $clog2(TEMP_BANDS) : 1;
    localparam int CW    = $clog2(MAX_LEVELS + 1);
    localparam int AW    = BW + LW;
    localparam int DEPTH = 1 << AW;

    state_t        state_reg;
    state_t        state_next;
    avtc_item_t    item_reg;
    avtc_item_t    item_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic          lv_reg;
    logic          lv_next;
    logic [11:0]   cv_reg;
    logic [11:0]   cv_next;
    logic          vv_reg;
    logic          vv_next;
    logic          cip_reg;
    logic          cip_next;
    logic [11:0]   fill_reg;
    logic [11:0]   fill_next;
    avtc_rsp_t     res_reg;
    avtc_rsp_t     res_next;
    logic          res_valid_reg;
    logic          res_valid_next;

    logic [11:0]   mem [DEPTH];
    logic [11:0]   rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [11:0]   mem_wdata;

    logic          pop;
    logic [CW-1:0] levels;
    logic [BW-1:0] band;
    logic [LW-1:0] in_level;
    logic [LW-1:0] drive_level;
    logic          go;
    logic [12:0]   raised;
    logic [11:0]   raise_v;
    logic          lower_ok;

    assign levels = ({3'b0, cfg.freq_count} > 9'(MAX_LEVELS)) ? CW'(MAX_LEVELS)
                                                               : CW'(cfg.freq_count);
    assign band        = BW'(item_reg.band);
    assign in_level    = LW'({4'b0, item.level});
    assign drive_level = (item_reg.kind == KIND_CHANGE) ? LW'({4'b0, item_reg.level})
                                                        : level_reg;
    assign go = item.begin_req ? (lv_reg && in_level > level_reg)
                               : (!lv_reg || in_level < level_reg);
    assign raised  = {1'b0, cv_reg} + {5'b0, cfg.vstep_mv};
    assign raise_v = (raised > {1'b0, cfg.vmax_mv}) ? cfg.vmax_mv : raised[11:0];
    assign lower_ok = ({1'b0, cv_reg} >= ({5'b0, cfg.vstep_mv} + {1'b0, cfg.vmin_mv}))
                      && (cv_reg <= rdata_reg);

    assign pop            = (state_reg == ST_IDLE) && item_valid && !res_valid_reg;
    assign bstat.pop      = pop;
    assign bstat.clearing = (state_reg == ST_CLEAR);
    assign rsp_valid      = res_valid_reg;
    assign rsp            = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (item.kind == KIND_CHANGE && go)
                    begin
                        state_next = ST_DRV_RD;
                    end
                    else if (item.kind == KIND_TICK && !cip_reg && lv_reg)
                    begin
                        case (item.action)
                            ACT_RAISE: state_next = ST_RAISE;
                            ACT_LOWER: state_next = ST_LOW_RD;
                            default:   state_next = ST_DRV_RD;
                        endcase
                    end
                end
            end
            ST_RAISE:
            begin
                if (cnt_reg >= levels)
                begin
                    state_next = ST_DRV_RD;
                end
            end
            ST_LOW_RD:    state_next = ST_LOW_CHK;
            ST_LOW_CHK:   state_next = lower_ok ? ST_SWEEP_RD : ST_DRV_RD;
            ST_SWEEP_RD:
            begin
                state_next = (LW'(cnt_reg) == level_reg) ? ST_DRV_RD : ST_SWEEP_CMP;
            end
            ST_SWEEP_CMP: state_next = ST_SWEEP_RD;
            ST_DRV_RD:    state_next = ST_DRV;
            ST_DRV:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_addr  = {band, level_reg};
        mem_we    = 1'b0;
        mem_wdata = fill_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = RESET_VMAX;
            end
            ST_RAISE:
            begin
                mem_addr = {band, LW'(cnt_reg)};
                mem_we   = (cnt_reg < levels);
            end
            ST_LOW_CHK:
            begin
                mem_we    = lower_ok;
                mem_wdata = cv_reg - {4'b0, cfg.vstep_mv};
            end
            ST_SWEEP_RD:  mem_addr = {band, LW'(cnt_reg)};
            ST_SWEEP_CMP:
            begin
                mem_addr = {band, LW'(cnt_reg)};
                mem_we   = (rdata_reg > fill_reg);
            end
            ST_DRV_RD:    mem_addr = {band, drive_level};
            default:      mem_addr = {band, level_reg};
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        level_next     = level_reg;
        lv_next        = lv_reg;
        cv_next        = cv_reg;
        vv_next        = vv_reg;
        cip_next       = cip_reg;
        fill_next      = fill_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !rsp_ready;
        case (state_reg)
            ST_CLEAR:     clr_next = clr_reg + AW'(1);
            ST_IDLE:
            begin
                if (pop)
                begin
                    item_next              = item;
                    cnt_next               = '0;
                    res_next               = '0;
                    res_next.status        = item.out_of_range;
                    if (item.kind == KIND_CHANGE)
                    begin
                        cip_next = item.begin_req;
                        if (!go)
                        begin
                            res_valid_next = 1'b1;
                        end
                    end
                    else if (item.kind == KIND_TICK && !cip_reg && lv_reg)
                    begin
                        if (item.action == ACT_ERROR)
                        begin
                            res_next.delay_error = 1'b1;
                        end
                        if (item.action == ACT_RAISE)
                        begin
                            res_next.at_max_warning = (cv_reg >= cfg.vmax_mv);
                            fill_next               = raise_v;
                        end
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_RAISE:     cnt_next = cnt_reg + CW'(1);
            ST_LOW_CHK:   fill_next = cv_reg - {4'b0, cfg.vstep_mv};
            ST_SWEEP_CMP: cnt_next = cnt_reg + CW'(1);
            ST_DRV:
            begin
                if (!vv_reg || rdata_reg != cv_reg)
                begin
                    cv_next                = rdata_reg;
                    vv_next                = 1'b1;
                    res_next.drive_valid   = 1'b1;
                    res_next.drive_voltage = rdata_reg;
                end
                if (item_reg.kind == KIND_CHANGE)
                begin
                    level_next = drive_level;
                    lv_next    = 1'b1;
                end
                res_valid_next = 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            level_reg     <= '0;
            lv_reg        <= 1'b0;
            cv_reg        <= '0;
            vv_reg        <= 1'b0;
            cip_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            level_reg     <= level_next;
            lv_reg        <= lv_next;
            cv_reg        <= cv_next;
            vv_reg        <= vv_next;
            cip_reg       <= cip_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cnt_reg  <= cnt_next;
        fill_reg <= fill_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

endmodule
